/* hw/rtl/congestion_count_reroute_trigger_macros.svh */
// Assertion helpers used by the checker file.
`ifndef CONGESTION_COUNT_REROUTE_TRIGGER_MACROS_SVH
`define CONGESTION_COUNT_REROUTE_TRIGGER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCRT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ccrt_pkg.sv */
package ccrt_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned KeyW          = 104;
  localparam int unsigned CountW        = 8;
  localparam int unsigned TimeW         = 48;
  localparam int unsigned LifeW         = 32;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 32;

  localparam logic [CountW-1:0] CountMax       = '1;
  localparam logic [CountW-1:0] CountNew       = CountW'(1);
  localparam logic [CountW-1:0] ThresholdReset = CountW'(2);
  localparam logic [LifeW-1:0]  LifetimeReset  = LifeW'(100000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_LIFETIME  = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } ccrt_state_e;

  typedef struct packed {
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [7:0]       protocol;
    logic [TimeW-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic reroute;
    logic record_found;
    logic dropped;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic lookup;
    logic update;
  } ccrt_cmd_t;

  typedef struct packed {
    logic out_free;
  } ccrt_status_t;

  function automatic logic [KeyW-1:0] key_of(input in_item_t item);
    return {item.src_addr, item.dst_addr, item.src_port, item.dst_port, item.protocol};
  endfunction

endpackage

/* hw/rtl/ccrt_ctrl.sv */
module ccrt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ccrt_pkg::ccrt_status_t status_i,
  output ccrt_pkg::ccrt_cmd_t    cmd_o
);
  import ccrt_pkg::*;

  ccrt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status_i.out_free) state_d = in_valid_i ? ST_LOOKUP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.lookup  = 1'b0;
    cmd_o.update  = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_UPDATE: begin
        in_ready_o   = status_i.out_free;
        cmd_o.update = status_i.out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
    cmd_o.load_in = in_valid_i && in_ready_o;
  end

endmodule

/* hw/rtl/ccrt_dp.sv */
module ccrt_dp #(
  parameter int unsigned TableDepth = ccrt_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ccrt_pkg::in_item_t            in_data_i,
  input  logic                          cfg_we_i,
  input  logic [ccrt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ccrt_pkg::CfgDataW-1:0] cfg_data_i,
  input  ccrt_pkg::ccrt_cmd_t           cmd_i,
  output ccrt_pkg::ccrt_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ccrt_pkg::out_item_t           out_data_o
);
  import ccrt_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  function automatic logic [IdxW-1:0] first_one(input logic [TableDepth-1:0] v);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (v[i]) idx = IdxW'(i);
    end
    return idx;
  endfunction

  in_item_t          item_q;
  logic [CountW-1:0] thr_q;
  logic [LifeW-1:0]  life_q;

  logic [TableDepth-1:0] valid_q, valid_d;
  logic [KeyW-1:0]       key_q   [TableDepth];
  logic [CountW-1:0]     count_q [TableDepth];
  logic [TimeW-1:0]      time_q  [TableDepth];

  logic [TableDepth-1:0] match_q, match_d;
  logic [TableDepth-1:0] exp_q, exp_d;

  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  logic [TableDepth-1:0] live, free_vec;
  logic                  hit_any, free_any, do_reroute;
  logic [IdxW-1:0]       hit_idx, free_idx;
  logic [CountW-1:0]     cnt_sel, cnt_inc;
  logic [KeyW-1:0]       key_in;

  // Per-entry expiry and key compare
  always_comb begin
    key_in = key_of(item_q);
    for (int i = 0; i < TableDepth; i++) begin
      exp_d[i]   = valid_q[i] &&
                   (({1'b0, time_q[i]} + (TimeW + 1)'(life_q)) < {1'b0, item_q.now_time});
      match_d[i] = valid_q[i] && !exp_d[i] && (key_q[i] == key_in);
    end
  end

  // Write-back decisions
  always_comb begin
    live       = valid_q & ~exp_q;
    free_vec   = ~live;
    hit_any    = |match_q;
    free_any   = |free_vec;
    hit_idx    = first_one(match_q);
    free_idx   = first_one(free_vec);
    cnt_sel    = count_q[hit_idx];
    cnt_inc    = (cnt_sel != CountMax) ? cnt_sel + CountNew : cnt_sel;
    do_reroute = cnt_inc >= thr_q;
    valid_d    = live;
    if (!hit_any && free_any) valid_d[free_idx] = 1'b1;
    out_data_d.reroute      = hit_any && do_reroute;
    out_data_d.record_found = hit_any;
    out_data_d.dropped      = !hit_any && !free_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= ThresholdReset;
      life_q      <= LifetimeReset;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_THRESHOLD: thr_q  <= cfg_data_i[CountW-1:0];
          CFG_LIFETIME:  life_q <= cfg_data_i[LifeW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        valid_q     <= valid_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) item_q <= in_data_i;
    if (cmd_i.lookup) begin
      match_q <= match_d;
      exp_q   <= exp_d;
    end
    if (cmd_i.update) begin
      out_data_q <= out_data_d;
      if (hit_any) begin
        count_q[hit_idx] <= do_reroute ? '0 : cnt_inc;
        time_q[hit_idx]  <= item_q.now_time;
      end else if (free_any) begin
        key_q[free_idx]   <= key_in;
        count_q[free_idx] <= CountNew;
        time_q[free_idx]  <= item_q.now_time;
      end
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

endmodule

/* hw/rtl/congestion_count_reroute_trigger.sv */
// Congestion-count reroute trigger.
// Input channel (in_valid_i/in_ready_o/in_data_i): one congestion signal per
// transfer, carrying the flow five-tuple and the current time.
// Output channel (out_valid_o/out_ready_i/out_data_o): one result per input
// transfer with reroute, record_found and dropped flags, in input order.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): index 0 is
// the reroute threshold, index 1 the record lifetime; always ready, write only
// while the block is idle.
// Result path: the input register is loaded on the transfer, then a lookup
// cycle registers the compare, then a write-back cycle loads the output register.
// Each item takes the lookup/write-back pair over the register-based flow
// table; a new input is taken in the write-back cycle of the previous one.
// If the receiver stalls, one result waits in the output register, the next
// item is taken and its lookup done, and it then holds in write-back until the
// output register frees.
// Reset: all table entries invalid, threshold 2, lifetime 100000, no result
// pending; no clearing pass.
module congestion_count_reroute_trigger #(
  parameter int unsigned TableDepth = ccrt_pkg::TableDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ccrt_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ccrt_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ccrt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ccrt_pkg::CfgDataW-1:0] cfg_data_i
);
  import ccrt_pkg::*;

  ccrt_cmd_t    cmd;
  ccrt_status_t status;

  assign cfg_ready_o = 1'b1;

  ccrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ccrt_dp #(
    .TableDepth (TableDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hw/rtl/ccrt_checker.sv */
`include "congestion_count_reroute_trigger_macros.svh"

module ccrt_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ccrt_pkg::out_item_t out_data_o
);

  `CCRT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")
  `CCRT_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o), "stalled result changed")
  `CCRT_ASSERT_NOW(a_reroute_hit, clk_i, rst_ni, out_valid_o && out_data_o.reroute, out_data_o.record_found && !out_data_o.dropped, "reroute without a live record")
  `CCRT_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken during lookup")

endmodule

bind congestion_count_reroute_trigger ccrt_checker u_ccrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* sim/congestion_count_reroute_trigger_test.sv */
module congestion_count_reroute_trigger_test;
  import ccrt_pkg::*;

  localparam int unsigned Depth    = TableDepthDef;
  localparam int unsigned PoolMax  = 24;
  localparam logic [CfgIdxW-1:0] CfgSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpare3 = CfgIdxW'(3);

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_THRESHOLD;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  congestion_count_reroute_trigger #(
    .TableDepth(Depth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // flow table mirror
  bit              flow_valid [Depth];
  logic [KeyW-1:0] flow_key   [Depth];
  logic [7:0]      flow_count [Depth];
  logic [47:0]     flow_seen  [Depth];
  logic [7:0]      cur_threshold;
  logic [31:0]     cur_lifetime;

  out_item_t   pending_results [$];
  in_item_t    flow_pool [PoolMax];
  logic [47:0] now_clock = '0;

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  hits_seen      = 0;
  int  reroutes_seen  = 0;
  int  drops_seen     = 0;
  int  sink_hold      = 0;
  int  stall_left     = 0;
  bit  steady         = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic out_item_t predict_signal(input in_item_t sig);
    logic [KeyW-1:0] key;
    int              hit;
    int              free_slot;
    out_item_t       res;
    key       = {sig.src_addr, sig.dst_addr, sig.src_port, sig.dst_port, sig.protocol};
    res       = '0;
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < Depth; i++) begin
      if (flow_valid[i] &&
          (({1'b0, flow_seen[i]} + {17'd0, cur_lifetime}) < {1'b0, sig.now_time})) begin
        flow_valid[i] = 1'b0;
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (flow_valid[i]) begin
        if (hit < 0 && flow_key[i] == key) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit >= 0) begin
      res.record_found = 1'b1;
      if (flow_count[hit] != 8'hFF) flow_count[hit] = flow_count[hit] + 8'd1;
      flow_seen[hit] = sig.now_time;
      if (flow_count[hit] >= cur_threshold) begin
        flow_count[hit] = '0;
        res.reroute     = 1'b1;
      end
    end else if (free_slot >= 0) begin
      flow_valid[free_slot] = 1'b1;
      flow_key[free_slot]   = key;
      flow_count[free_slot] = 8'd1;
      flow_seen[free_slot]  = sig.now_time;
    end else begin
      res.dropped = 1'b1;
    end
    return res;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual %b", $time, got);
      return;
    end
    want = pending_results.pop_front();
    results_seen++;
    hits_seen     += want.record_found;
    reroutes_seen += want.reroute;
    drops_seen    += want.dropped;
    if (got.reroute !== want.reroute) begin
      mismatch_count++;
      $display("%0t: reroute expected %b actual %b", $time, want.reroute, got.reroute);
    end
    if (got.record_found !== want.record_found) begin
      mismatch_count++;
      $display("%0t: record_found expected %b actual %b", $time, want.record_found,
               got.record_found);
    end
    if (got.dropped !== want.dropped) begin
      mismatch_count++;
      $display("%0t: dropped expected %b actual %b", $time, want.dropped, got.dropped);
    end
  endtask

  // result sink: checks at the falling edge, drives ready at the rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        check_result(out_data_o);
        stall_left = steady ? 0 : $urandom_range(0, 11);
      end
      @(posedge clk_i);
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_signal(input in_item_t sig);
    int gap;
    bit took;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= sig;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    pending_results.insert(pending_results.size(), predict_signal(sig));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    bit took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD: cur_threshold = data[7:0];
      CFG_LIFETIME:  cur_lifetime  = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic await_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] thr, input logic [31:0] life);
    await_idle();
    write_reg(CFG_THRESHOLD, {24'($urandom), thr});
    write_reg(CFG_LIFETIME, life);
  endtask

  function automatic in_item_t random_flow();
    in_item_t f;
    f.src_addr = $urandom;
    f.dst_addr = $urandom;
    f.src_port = 16'($urandom);
    f.dst_port = 16'($urandom);
    f.protocol = 8'($urandom);
    f.now_time = '0;
    return f;
  endfunction

  function automatic in_item_t at_time(input in_item_t f, input logic [47:0] t);
    f.now_time = t;
    return f;
  endfunction

  // some entries differ from their neighbor in a single key bit
  task automatic make_flow_pool(input int n);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        flow_pool[i] = flow_pool[i-1];
        case ($urandom_range(0, 4))
          0: flow_pool[i].src_addr[$urandom_range(0, 31)] ^= 1'b1;
          1: flow_pool[i].dst_addr[$urandom_range(0, 31)] ^= 1'b1;
          2: flow_pool[i].src_port[$urandom_range(0, 15)] ^= 1'b1;
          3: flow_pool[i].dst_port[$urandom_range(0, 15)] ^= 1'b1;
          default: flow_pool[i].protocol[$urandom_range(0, 7)] ^= 1'b1;
        endcase
      end else begin
        flow_pool[i] = random_flow();
      end
    end
  endtask

  task automatic run_traffic(input int count, input int pool_n, input int unsigned max_step,
                             input bit jumps);
    int       pick;
    in_item_t sig;
    make_flow_pool(pool_n);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 10) sig = random_flow();
      else sig = flow_pool[$urandom_range(0, pool_n - 1)];
      pick = $urandom_range(0, 99);
      if (jumps && pick < 3) begin
        now_clock = now_clock - 48'($urandom_range(0, max_step * 4));
      end else if (jumps && pick < 6) begin
        now_clock = now_clock + 48'(cur_lifetime) + 48'($urandom_range(1, 1000));
      end else begin
        now_clock = now_clock + 48'($urandom_range(0, max_step));
      end
      send_signal(at_time(sig, now_clock));
    end
    steady = 1'b0;
  endtask

  // runs on reset values of both registers
  task automatic test_basics();
    send_signal(at_time('0, 48'd0));
    send_signal(at_time('0, 48'd10));
    send_signal(at_time('0, 48'd20));
    send_signal(at_time('1, 48'd30));
    send_signal(at_time('0, 48'd100020));
    send_signal(at_time('1, 48'd100031));
    send_signal(at_time('0, 48'd50));
  endtask

  task automatic test_table_full();
    for (int n = 0; n < Depth - 2; n++) send_signal(at_time(random_flow(), 48'd100040));
    send_signal(at_time(random_flow(), 48'd100040));
    send_signal(at_time('0, 48'd100040));
    send_signal(at_time(random_flow(), 48'd100051));
  endtask

  task automatic test_time_extremes();
    await_idle();
    write_reg(CFG_LIFETIME, '1);
    send_signal(at_time('1, '1));
    send_signal(at_time('1, '1));
    send_signal(at_time('1, 48'd0));
  endtask

  task automatic test_threshold_zero();
    set_config(8'd0, 32'd1000);
    run_traffic(130, 12, 100, 1'b1);
  endtask

  task automatic test_threshold_one();
    set_config(8'd1, 32'd0);
    run_traffic(110, 8, 1, 1'b1);
  endtask

  task automatic test_count_ceiling();
    set_config(8'd255, '1);
    run_traffic(290, 1, 1000, 1'b0);
  endtask

  task automatic test_wide_lifetime();
    set_config(8'd3, '1);
    run_traffic(130, 24, 1 << 20, 1'b1);
  endtask

  task automatic test_backpressure();
    set_config(8'd2, 32'd300);
    sink_hold = 80;
    run_traffic(75, 16, 30, 1'b1);
    sink_hold = 120;
    run_traffic(75, 16, 30, 1'b1);
  endtask

  task automatic test_mixed();
    logic [31:0] life;
    await_idle();
    write_reg(CfgSpare2, $urandom);
    write_reg(CfgSpare3, $urandom);
    run_traffic(50, 20, 200, 1'b1);
    for (int p = 0; p < 3; p++) begin
      life = $urandom_range(0, 2000);
      set_config(8'($urandom_range(0, 8)), life);
      run_traffic(50, $urandom_range(4, PoolMax), life / 10 + 1, 1'b1);
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) flow_valid[i] = 1'b0;
    cur_threshold = ThresholdReset;
    cur_lifetime  = LifetimeReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basics();
    test_table_full();
    test_time_extremes();
    test_threshold_zero();
    test_threshold_one();
    test_count_ceiling();
    test_wide_lifetime();
    test_backpressure();
    test_mixed();

    in_valid_i <= 1'b0;
    for (int w = 0; w < 5000 && pending_results.size() != 0; w++) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      mismatch_count += pending_results.size();
      $display("%0t: expected %0d more results, actual none", $time, pending_results.size());
    end
    repeat (10) @(posedge clk_i);
    $display("checked %0d congestion signals: %0d hits, %0d reroutes, %0d dropped misses",
             results_seen, hits_seen, reroutes_seen, drops_seen);
    $display("thresholds 0 to 255, lifetimes 0 to max, expiry, full table, long output stalls");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
